/* hw/rtl/dmfp_pkg.sv */
`timescale 1ns / 1ps

package dmfp_pkg;

   localparam logic [3:0] KIND_ID        = 4'd0;
   localparam logic [3:0] KIND_FLAGS     = 4'd1;
   localparam logic [3:0] KIND_QDCOUNT   = 4'd2;
   localparam logic [3:0] KIND_ANCOUNT   = 4'd3;
   localparam logic [3:0] KIND_NSCOUNT   = 4'd4;
   localparam logic [3:0] KIND_ARCOUNT   = 4'd5;
   localparam logic [3:0] KIND_QTYPE     = 4'd6;
   localparam logic [3:0] KIND_QCLASS    = 4'd7;
   localparam logic [3:0] KIND_ATYPE     = 4'd8;
   localparam logic [3:0] KIND_ACLASS    = 4'd9;
   localparam logic [3:0] KIND_TTL       = 4'd10;
   localparam logic [3:0] KIND_RDLENGTH  = 4'd11;
   localparam logic [3:0] KIND_IPV4      = 4'd12;
   localparam logic [3:0] KIND_MX_PREF   = 4'd13;
   localparam logic [3:0] KIND_END       = 4'd14;

   localparam logic [31:0] END_COMPLETE  = 32'd0;
   localparam logic [31:0] END_TRUNCATED = 32'd1;

   localparam logic [15:0] RR_TYPE_A     = 16'd1;
   localparam logic [15:0] RR_TYPE_MX    = 16'd15;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] value;
      logic [15:0] record;
      logic        last;
   } result_type;

endpackage

/* hw/rtl/dns_message_field_parser.sv */
`timescale 1ns / 1ps

// DNS message field parser. Takes one message byte per beat on the req side
// (tuser marks the first byte of a message, tlast the final byte) and returns
// decoded header, question and answer fields on the rsp side, kind in tuser.
// A byte is taken every cycle: it is registered, decoded in one pass by the
// parse state update, and its zero, one or two result beats go into a
// four-entry result queue, so a field's beat reaches rsp once its last byte
// has passed the input register and the parse state update into the queue.
// The result port moves one beat per cycle while rsp_tready is high; only
// the final byte of a message, when it also completes a field, makes two
// beats, and the queue absorbs that, so req stalls only when rsp is held back.
module dns_message_field_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte [7:0]
   input  logic        req_tuser,   // message_start
   input  logic        req_tlast,   // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // field_value [31:0], record_number [47:32], query_response [48],
   // op_code [52:49], authoritative [53], truncated_flag [54],
   // recursion_desired [55], recursion_available [56], response_code [60:57],
   // zero [63:61]
   output logic [63:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,   // field_kind
   output logic        rsp_tlast    // last_of_run
);
   import dmfp_pkg::*;

   typedef enum logic [3:0] {
      PH_ID     = 4'd0,
      PH_FLAGS  = 4'd1,
      PH_QD     = 4'd2,
      PH_AN     = 4'd3,
      PH_NS     = 4'd4,
      PH_AR     = 4'd5,
      PH_QNAME  = 4'd6,
      PH_QTYPE  = 4'd7,
      PH_QCLASS = 4'd8,
      PH_ANAME  = 4'd9,
      PH_ATYPE  = 4'd10,
      PH_ACLASS = 4'd11,
      PH_ATTL   = 4'd12,
      PH_ARDLEN = 4'd13,
      PH_ARDATA = 4'd14,
      PH_DONE   = 4'd15
   } phase_type;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        in_end_ff;
   logic        proc;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [2:0]  fbc_ff, fbc_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] qleft_ff, qleft_in;
   logic [15:0] aleft_ff, aleft_in;
   logic [15:0] rec_ff, rec_in;
   logic [15:0] atype_ff, atype_in;
   logic [15:0] rdleft_ff, rdleft_in;
   logic [7:0]  lleft_ff, lleft_in;

   // results of the current byte
   result_type  res0, res1;
   logic [1:0]  nres;

   // result queue
   result_type  queue_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pop;
   result_type  head;

   assign proc       = in_valid_ff && (cnt_ff <= 3'd2);
   assign req_tready = !in_valid_ff || proc;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      logic [31:0] v;
      logic        done_field;
      logic        need4;
      phase_type   ph;
      logic [2:0]  fbc;
      logic [31:0] acc;
      logic [15:0] qleft;
      logic [15:0] aleft;
      logic [15:0] rec;
      logic [15:0] atype;
      logic [15:0] rdleft;
      logic [7:0]  lleft;
      logic [7:0]  b;

      b      = in_byte_ff;
      ph     = phase_ff;
      fbc    = fbc_ff;
      acc    = acc_ff;
      qleft  = qleft_ff;
      aleft  = aleft_ff;
      rec    = rec_ff;
      atype  = atype_ff;
      rdleft = rdleft_ff;
      lleft  = lleft_ff;
      res0   = '0;
      res1   = '0;
      nres   = 2'd0;
      v      = '0;
      done_field = 1'b0;
      need4  = 1'b0;

      if (in_start_ff) begin
         ph     = PH_ID;
         fbc    = '0;
         acc    = '0;
         qleft  = '0;
         aleft  = '0;
         rec    = '0;
         atype  = '0;
         rdleft = '0;
         lleft  = '0;
      end

      case (ph)
         PH_QNAME, PH_ANAME: begin
            acc = '0;
            if (fbc == 3'd2) begin
               fbc = '0;
               ph  = (ph == PH_QNAME) ? PH_QTYPE : PH_ATYPE;
            end else if (fbc == 3'd1) begin
               lleft = 8'(lleft - 8'd1);
               if (lleft == 8'd0) begin
                  fbc = '0;
               end
            end else if (b == 8'd0) begin
               ph = (ph == PH_QNAME) ? PH_QTYPE : PH_ATYPE;
            end else if (b[7:6] == 2'b11) begin
               fbc = 3'd2;
            end else begin
               lleft = {2'b00, b[5:0]};
               fbc   = (lleft != 8'd0) ? 3'd1 : 3'd0;
            end
         end
         PH_ARDATA: begin
            rdleft = 16'(rdleft - 16'd1);
            if (fbc < 3'd4) begin
               acc = {acc[23:0], b};
               fbc = 3'(fbc + 3'd1);
               if (atype == RR_TYPE_A && fbc == 3'd4) begin
                  res0 = '{kind: KIND_IPV4, value: acc, record: rec, last: 1'b0};
                  nres = 2'd1;
               end else if (atype == RR_TYPE_MX && fbc == 3'd2) begin
                  res0 = '{kind: KIND_MX_PREF, value: {16'd0, acc[15:0]}, record: rec,
                           last: 1'b0};
                  nres = 2'd1;
               end
            end
            if (rdleft == 16'd0) begin
               fbc   = '0;
               acc   = '0;
               aleft = 16'(aleft - 16'd1);
               rec   = 16'(rec + 16'd1);
               ph    = (aleft != 16'd0) ? PH_ANAME : PH_DONE;
            end
         end
         PH_DONE: begin
         end
         default: begin
            need4 = (ph == PH_ATTL);
            acc   = {acc[23:0], b};
            fbc   = 3'(fbc + 3'd1);
            done_field = need4 ? (fbc >= 3'd4) : (fbc >= 3'd2);
            if (done_field) begin
               v = need4 ? acc : {16'd0, acc[15:0]};
               res0.value  = v;
               res0.record = rec;
               res0.last   = 1'b0;
               case (ph)
                  PH_ID:     res0.kind = KIND_ID;
                  PH_FLAGS:  res0.kind = KIND_FLAGS;
                  PH_QD:     res0.kind = KIND_QDCOUNT;
                  PH_AN:     res0.kind = KIND_ANCOUNT;
                  PH_NS:     res0.kind = KIND_NSCOUNT;
                  PH_AR:     res0.kind = KIND_ARCOUNT;
                  PH_QTYPE:  res0.kind = KIND_QTYPE;
                  PH_QCLASS: res0.kind = KIND_QCLASS;
                  PH_ATYPE:  res0.kind = KIND_ATYPE;
                  PH_ACLASS: res0.kind = KIND_ACLASS;
                  PH_ATTL:   res0.kind = KIND_TTL;
                  PH_ARDLEN: res0.kind = KIND_RDLENGTH;
                  default:   res0.kind = KIND_ID;
               endcase
               nres = 2'd1;
               fbc  = '0;
               acc  = '0;
               case (ph)
                  PH_ID:    ph = PH_FLAGS;
                  PH_FLAGS: ph = PH_QD;
                  PH_QD: begin
                     qleft = v[15:0];
                     ph    = PH_AN;
                  end
                  PH_AN: begin
                     aleft = v[15:0];
                     ph    = PH_NS;
                  end
                  PH_NS:    ph = PH_AR;
                  PH_AR: begin
                     rec = '0;
                     if (qleft != 16'd0) begin
                        ph = PH_QNAME;
                     end else begin
                        ph = (aleft != 16'd0) ? PH_ANAME : PH_DONE;
                     end
                  end
                  PH_QTYPE: ph = PH_QCLASS;
                  PH_QCLASS: begin
                     qleft = 16'(qleft - 16'd1);
                     rec   = 16'(rec + 16'd1);
                     if (qleft != 16'd0) begin
                        ph = PH_QNAME;
                     end else begin
                        rec = '0;
                        ph  = (aleft != 16'd0) ? PH_ANAME : PH_DONE;
                     end
                  end
                  PH_ATYPE: begin
                     atype = v[15:0];
                     ph    = PH_ACLASS;
                  end
                  PH_ACLASS: ph = PH_ATTL;
                  PH_ATTL:   ph = PH_ARDLEN;
                  PH_ARDLEN: begin
                     rdleft = v[15:0];
                     if (rdleft == 16'd0) begin
                        aleft = 16'(aleft - 16'd1);
                        rec   = 16'(rec + 16'd1);
                        ph    = (aleft != 16'd0) ? PH_ANAME : PH_DONE;
                     end else begin
                        ph = PH_ARDATA;
                     end
                  end
                  default: ph = PH_DONE;
               endcase
            end
         end
      endcase

      if (in_end_ff) begin
         if (nres == 2'd0) begin
            res0 = '{kind: KIND_END,
                     value: (ph == PH_DONE) ? END_COMPLETE : END_TRUNCATED,
                     record: rec, last: 1'b0};
         end else begin
            res1 = '{kind: KIND_END,
                     value: (ph == PH_DONE) ? END_COMPLETE : END_TRUNCATED,
                     record: rec, last: 1'b0};
         end
         nres   = 2'(nres + 2'd1);
         ph     = PH_ID;
         fbc    = '0;
         acc    = '0;
         qleft  = '0;
         aleft  = '0;
         rec    = '0;
         atype  = '0;
         rdleft = '0;
         lleft  = '0;
      end

      if (nres == 2'd2) begin
         res1.last = 1'b1;
      end else begin
         res0.last = 1'b1;
      end

      phase_in  = ph;
      fbc_in    = fbc;
      acc_in    = acc;
      qleft_in  = qleft;
      aleft_in  = aleft;
      rec_in    = rec;
      atype_in  = atype;
      rdleft_in = rdleft;
      lleft_in  = lleft;
   end

   assign pop  = rsp_tvalid && rsp_tready;
   assign head = queue_ff[rd_ptr_ff];

   always_comb begin
      logic [1:0] push_n;
      push_n    = proc ? nres : 2'd0;
      wr_ptr_in = 2'(wr_ptr_ff + push_n);
      rd_ptr_in = pop ? 2'(rd_ptr_ff + 2'd1) : rd_ptr_ff;
      cnt_in    = 3'(cnt_ff + {1'b0, push_n} - {2'b00, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_ID;
         fbc_ff      <= '0;
         acc_ff      <= '0;
         qleft_ff    <= '0;
         aleft_ff    <= '0;
         rec_ff      <= '0;
         atype_ff    <= '0;
         rdleft_ff   <= '0;
         lleft_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (proc) begin
            phase_ff  <= phase_in;
            fbc_ff    <= fbc_in;
            acc_ff    <= acc_in;
            qleft_ff  <= qleft_in;
            aleft_ff  <= aleft_in;
            rec_ff    <= rec_in;
            atype_ff  <= atype_in;
            rdleft_ff <= rdleft_in;
            lleft_ff  <= lleft_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
         in_end_ff   <= req_tlast;
      end
      if (proc && nres != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (proc && nres == 2'd2) begin
         queue_ff[2'(wr_ptr_ff + 2'd1)] <= res1;
      end
   end

   always_comb begin
      logic fl;
      fl = (head.kind == KIND_FLAGS);
      rsp_tvalid       = (cnt_ff != 3'd0);
      rsp_tuser        = head.kind;
      rsp_tlast        = head.last;
      rsp_tdata        = '0;
      rsp_tdata[31:0]  = head.value;
      rsp_tdata[47:32] = head.record;
      rsp_tdata[48]    = fl & head.value[15];
      rsp_tdata[52:49] = fl ? head.value[14:11] : 4'd0;
      rsp_tdata[53]    = fl & head.value[10];
      rsp_tdata[54]    = fl & head.value[9];
      rsp_tdata[55]    = fl & head.value[8];
      rsp_tdata[56]    = fl & head.value[7];
      rsp_tdata[60:57] = fl ? head.value[3:0] : 4'd0;
   end

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result queue overflow");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast)
      else $error("end beat without tlast");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      proc && in_end_ff |=> phase_ff == PH_ID && cnt_ff != 3'd0)
      else $error("end byte did not restart parser or queue end beat");

   a_reset_phase: assert property (@(posedge clock)
      reset |=> phase_ff == PH_ID && cnt_ff == 3'd0)
      else $error("reset state wrong");
`endif

endmodule
